>>> hw/rtl/avc_tag_to_annexb_converter_macros.svh
// Assertion helpers shared by the converter modules.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef AVC_TAG_TO_ANNEXB_CONVERTER_MACROS_SVH
`define AVC_TAG_TO_ANNEXB_CONVERTER_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define AVC2AB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define AVC2AB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/avc2ab_pkg.sv
`timescale 1ns / 1ps
package avc2ab_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_STARTED = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    // Work for the output side, one entry per input byte that yields results.
    // Items go out in field order: started, error, start code, byte, complete.
    typedef struct packed {
        logic               started;
        logic               error;
        logic               start;
        logic               data;
        logic               complete;
        logic [7:0]         byte_val;
        logic signed [33:0] pts;
        logic [7:0]         profile;
    } t_cmd;

endpackage

>>> hw/rtl/avc2ab_front.sv
`timescale 1ns / 1ps
module avc2ab_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic [31:0]       i_packet_timestamp,
    output logic              o_push,
    output avc2ab_pkg::t_cmd  o_cmd
);
    import avc2ab_pkg::*;

    localparam logic [7:0] PKT_SEQ_HDR = 8'd0;
    localparam logic [7:0] PKT_NALU    = 8'd1;
    localparam logic [7:0] PKT_EOS     = 8'd2;
    localparam logic [1:0] LSC_UNSUP   = 2'd2;
    localparam logic [1:0] LSC_TWO     = 2'd1;
    localparam logic [1:0] LSC_FOUR    = 2'd3;
    localparam logic [7:0] EOS_NAL     = 8'h6A;

    typedef enum logic [10:0] {
        PH_HEADER    = 11'b000_0000_0001,
        PH_NAL_PFX   = 11'b000_0000_0010,
        PH_NAL_DATA  = 11'b000_0000_0100,
        PH_SPS_LEN   = 11'b000_0000_1000,
        PH_SPS_DATA  = 11'b000_0001_0000,
        PH_PPS_COUNT = 11'b000_0010_0000,
        PH_PPS_LEN   = 11'b000_0100_0000,
        PH_PPS_DATA  = 11'b000_1000_0000,
        PH_TRAIL     = 11'b001_0000_0000,
        PH_WAIT      = 11'b010_0000_0000,
        PH_DISCARD   = 11'b100_0000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [7:0]  r_ptype, n_ptype;
    logic [23:0] r_off, n_off;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_pbl, n_pbl;
    logic [31:0] r_left, n_left;
    logic [4:0]  r_sps, n_sps;
    logic [7:0]  r_pps, n_pps;
    logic [1:0]  r_lsc, n_lsc;
    logic        r_info, n_info;
    logic [7:0]  r_prof, n_prof;

    t_cmd        cmd;
    logic [15:0] len16;
    logic [31:0] acc_sh;
    logic [4:0]  sps_dec;
    logic [7:0]  pps_dec;
    logic        eos;

    // Prefix size in bytes for the latched size code
    function automatic logic [2:0] prefix_size(input logic [1:0] lsc);
        logic [2:0] sz;
        sz = 3'd1;
        if (lsc == LSC_FOUR) begin
            sz = 3'd4;
        end else if (lsc == LSC_TWO) begin
            sz = 3'd2;
        end
        return sz;
    endfunction

    // Step the parser over one byte and describe the results it causes
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_ptype = r_ptype;
        n_off   = r_off;
        n_acc   = r_acc;
        n_pbl   = r_pbl;
        n_left  = r_left;
        n_sps   = r_sps;
        n_pps   = r_pps;
        n_lsc   = r_lsc;
        n_info  = r_info;
        n_prof  = r_prof;
        cmd     = '0;
        eos     = 1'b0;
        acc_sh  = {r_acc[23:0], i_data_byte};
        len16   = {r_acc[7:0], i_data_byte};
        sps_dec = r_sps - 5'd1;
        pps_dec = r_pps - 8'd1;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_pos == 4'd1) begin
                    n_ptype = i_data_byte;
                end else if (r_pos >= 4'd2 && r_pos <= 4'd4) begin
                    n_off = {r_off[15:0], i_data_byte};
                end else if (r_pos >= 4'd5 && r_pos <= 4'd9) begin
                    n_acc = acc_sh;
                end else if (r_pos == 4'd10) begin
                    if (!r_info) begin
                        n_prof      = r_acc[31:24];
                        n_lsc       = r_acc[1:0];
                        n_info      = 1'b1;
                        cmd.started = 1'b1;
                    end
                    n_sps = i_data_byte[4:0];
                    if (i_data_byte[4:0] != 5'd0) begin
                        n_phase = PH_SPS_LEN;
                        n_pbl   = 3'd2;
                        n_acc   = '0;
                    end else begin
                        n_phase = PH_PPS_COUNT;
                    end
                end
                // Packet type is known once the composition offset is in
                if (r_pos == 4'd4) begin
                    if (r_ptype == PKT_NALU) begin
                        if (r_lsc == LSC_UNSUP) begin
                            cmd.error = 1'b1;
                            n_phase   = PH_DISCARD;
                        end else begin
                            n_phase = PH_NAL_PFX;
                            n_pbl   = prefix_size(r_lsc);
                            n_acc   = '0;
                        end
                    end else if (r_ptype != PKT_SEQ_HDR) begin
                        n_phase = PH_WAIT;
                    end else begin
                        n_acc = '0;
                    end
                end
                if (r_pos != 4'd15) begin
                    n_pos = r_pos + 4'd1;
                end
            end
            PH_NAL_PFX: begin
                n_acc = acc_sh;
                n_pbl = r_pbl - 3'd1;
                if (r_pbl == 3'd1) begin
                    cmd.start = 1'b1;
                    n_left    = acc_sh;
                    if (acc_sh != '0) begin
                        n_phase = PH_NAL_DATA;
                    end else begin
                        n_pbl = prefix_size(r_lsc);
                        n_acc = '0;
                    end
                end
            end
            PH_NAL_DATA: begin
                cmd.data = 1'b1;
                n_left   = r_left - 32'd1;
                if (r_left == 32'd1) begin
                    n_phase = PH_NAL_PFX;
                    n_pbl   = prefix_size(r_lsc);
                    n_acc   = '0;
                end
            end
            PH_SPS_LEN, PH_PPS_LEN: begin
                n_acc = {16'd0, len16};
                n_pbl = r_pbl - 3'd1;
                if (r_pbl == 3'd1) begin
                    cmd.start = 1'b1;
                    n_left    = {16'd0, len16};
                    if (len16 != 16'd0) begin
                        n_phase = (r_phase == PH_SPS_LEN) ? PH_SPS_DATA : PH_PPS_DATA;
                    end else if (r_phase == PH_SPS_LEN) begin
                        n_sps = sps_dec;
                        if (sps_dec != 5'd0) begin
                            n_pbl = 3'd2;
                            n_acc = '0;
                        end else begin
                            n_phase = PH_PPS_COUNT;
                        end
                    end else begin
                        n_pps = pps_dec;
                        if (pps_dec != 8'd0) begin
                            n_pbl = 3'd2;
                            n_acc = '0;
                        end else begin
                            n_phase = PH_TRAIL;
                        end
                    end
                end
            end
            PH_SPS_DATA: begin
                cmd.data = 1'b1;
                n_left   = r_left - 32'd1;
                if (r_left == 32'd1) begin
                    n_sps = sps_dec;
                    if (sps_dec != 5'd0) begin
                        n_phase = PH_SPS_LEN;
                        n_pbl   = 3'd2;
                        n_acc   = '0;
                    end else begin
                        n_phase = PH_PPS_COUNT;
                    end
                end
            end
            PH_PPS_DATA: begin
                cmd.data = 1'b1;
                n_left   = r_left - 32'd1;
                if (r_left == 32'd1) begin
                    n_pps = pps_dec;
                    if (pps_dec != 8'd0) begin
                        n_phase = PH_PPS_LEN;
                        n_pbl   = 3'd2;
                        n_acc   = '0;
                    end else begin
                        n_phase = PH_TRAIL;
                    end
                end
            end
            PH_PPS_COUNT: begin
                n_pps = i_data_byte;
                if (i_data_byte != 8'd0) begin
                    n_phase = PH_PPS_LEN;
                    n_pbl   = 3'd2;
                    n_acc   = '0;
                end else begin
                    n_phase = PH_TRAIL;
                end
            end
            PH_TRAIL, PH_WAIT, PH_DISCARD: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // Close the packet: end-of-sequence code and completion report
        if (i_last_byte) begin
            if (n_phase == PH_NAL_PFX || n_phase == PH_NAL_DATA) begin
                cmd.complete = 1'b1;
                cmd.pts      = $signed({2'b00, i_packet_timestamp})
                             + $signed({{10{n_off[23]}}, n_off});
            end else if (n_phase == PH_SPS_LEN || n_phase == PH_SPS_DATA ||
                         n_phase == PH_PPS_COUNT || n_phase == PH_PPS_LEN ||
                         n_phase == PH_PPS_DATA || n_phase == PH_TRAIL ||
                         n_phase == PH_WAIT) begin
                cmd.complete = 1'b1;
                cmd.pts      = $signed({2'b00, i_packet_timestamp});
                if (n_phase == PH_WAIT && n_ptype == PKT_EOS) begin
                    eos       = 1'b1;
                    cmd.start = 1'b1;
                    cmd.data  = 1'b1;
                end
            end
            n_phase = PH_HEADER;
            n_pos   = '0;
            n_ptype = '0;
            n_off   = '0;
            n_acc   = '0;
            n_pbl   = '0;
            n_left  = '0;
            n_sps   = '0;
            n_pps   = '0;
        end

        cmd.byte_val = eos ? EOS_NAL : i_data_byte;
        cmd.profile  = n_prof;
    end

    // Advance parser state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_ptype <= '0;
            r_off   <= '0;
            r_acc   <= '0;
            r_pbl   <= '0;
            r_left  <= '0;
            r_sps   <= '0;
            r_pps   <= '0;
            r_lsc   <= '0;
            r_info  <= 1'b0;
            r_prof  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_ptype <= n_ptype;
            r_off   <= n_off;
            r_acc   <= n_acc;
            r_pbl   <= n_pbl;
            r_left  <= n_left;
            r_sps   <= n_sps;
            r_pps   <= n_pps;
            r_lsc   <= n_lsc;
            r_info  <= n_info;
            r_prof  <= n_prof;
        end
    end

    assign o_push = i_accept &&
                    (cmd.started || cmd.error || cmd.start || cmd.data || cmd.complete);
    assign o_cmd  = cmd;

endmodule

>>> hw/rtl/avc2ab_queue.sv
`timescale 1ns / 1ps
`include "avc_tag_to_annexb_converter_macros.svh"
module avc2ab_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  avc2ab_pkg::t_cmd  i_data,
    output logic              o_full,
    output logic              o_vld,
    output avc2ab_pkg::t_cmd  o_data,
    input  logic              i_pop
);
    import avc2ab_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    // Wrap pointers and track occupancy
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full = (r_cnt == CW'(DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_data = r_mem[r_rd];

    `AVC2AB_ASSERT_IMP(a_no_overflow, i_push && !i_pop, r_cnt != CW'(DEPTH), "queue overflow")
    `AVC2AB_ASSERT_IMP(a_no_underflow, i_pop, r_cnt != '0, "queue underflow")
    `AVC2AB_ASSERT_NEXT(a_push_seen, i_push && !i_pop, r_cnt != '0, "pushed entry lost")

endmodule

>>> hw/rtl/avc2ab_back.sv
`timescale 1ns / 1ps
`include "avc_tag_to_annexb_converter_macros.svh"
module avc2ab_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_vld,
    input  avc2ab_pkg::t_cmd    i_q_data,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output avc2ab_pkg::t_kind   o_kind,
    output logic [7:0]          o_out_byte,
    output logic signed [33:0]  o_presentation_time,
    output logic [7:0]          o_profile,
    output logic                o_last_of_run
);
    import avc2ab_pkg::*;

    logic               r_cur_vld;
    t_cmd               r_cur;
    logic [1:0]         r_sc;
    logic               r_out_vld;
    t_kind              r_kind;
    logic [7:0]         r_byte;
    logic signed [33:0] r_pts;
    logic [7:0]         r_prof;
    logic               r_last;

    t_cmd               cur;
    t_cmd               rem;
    logic               cur_vld;
    logic [1:0]         idx;
    logic [1:0]         rem_sc;
    logic               rem_any;
    logic               load;
    logic               fire;
    t_kind              n_kind;
    logic [7:0]         n_byte;
    logic signed [33:0] n_pts;
    logic [7:0]         n_prof;

    // Pick the next item of the entry in work, or of the queue head
    always_comb begin
        cur     = r_cur_vld ? r_cur : i_q_data;
        cur_vld = r_cur_vld || i_q_vld;
        idx     = r_cur_vld ? r_sc : 2'd0;
        rem     = cur;
        rem_sc  = idx;
        n_kind  = KIND_BYTE;
        n_byte  = '0;
        n_pts   = '0;
        n_prof  = '0;
        if (cur.started) begin
            n_kind      = KIND_STARTED;
            n_prof      = cur.profile;
            rem.started = 1'b0;
        end else if (cur.error) begin
            n_kind    = KIND_ERROR;
            rem.error = 1'b0;
        end else if (cur.start) begin
            n_byte = (idx == 2'd2) ? 8'h01 : 8'h00;
            if (idx == 2'd2) begin
                rem.start = 1'b0;
                rem_sc    = 2'd0;
            end else begin
                rem_sc = idx + 2'd1;
            end
        end else if (cur.data) begin
            n_byte   = cur.byte_val;
            rem.data = 1'b0;
        end else begin
            n_kind       = KIND_DONE;
            n_pts        = cur.pts;
            n_prof       = cur.profile;
            rem.complete = 1'b0;
        end
        rem_any = rem.started || rem.error || rem.start || rem.data || rem.complete;
        load    = !r_out_vld || !i_stall;
        fire    = load && cur_vld;
    end

    assign o_q_pop = fire && !r_cur_vld;

    // Hold the remainder of the entry and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_sc      <= '0;
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_cur_vld <= rem_any;
            r_sc      <= rem_sc;
            r_out_vld <= 1'b1;
        end else if (load) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_cur  <= rem;
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_pts  <= n_pts;
            r_prof <= n_prof;
            r_last <= !rem_any;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_kind              = r_kind;
    assign o_out_byte          = r_byte;
    assign o_presentation_time = r_pts;
    assign o_profile           = r_prof;
    assign o_last_of_run       = r_last;

    `AVC2AB_ASSERT_IMP(a_cur_pending, r_cur_vld,
        r_cur.started || r_cur.error || r_cur.start || r_cur.data || r_cur.complete,
        "entry in work has nothing left")
    `AVC2AB_ASSERT_IMP(a_done_is_last, r_out_vld && r_kind == KIND_DONE, r_last,
        "packet complete not last of run")
    `AVC2AB_ASSERT_IMP(a_sc_range, r_cur_vld, r_sc != 2'd3, "start code step out of range")

endmodule

>>> hw/rtl/avc_tag_to_annexb_converter.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_data_byte, i_last_byte, i_packet_timestamp
// output    out        o_valid / i_stall   o_kind, o_out_byte, o_presentation_time,
//                                          o_profile, o_last_of_run
//
// One payload byte is taken per cycle while the queue has room, also when it yields no
// result. Each result is one transfer on the output, one per cycle while i_stall is low,
// and a byte yields up to five results.
// The queue of QUEUE_DEPTH entries between parser and output sequencer absorbs bursts.
// Reset is synchronous, active low, and clears parser state and the queue.
// o_stall rises only when the queue is full.
module avc_tag_to_annexb_converter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    input  logic [31:0]        i_packet_timestamp,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_out_byte,
    output logic signed [33:0] o_presentation_time,
    output logic [7:0]         o_profile,
    output logic               o_last_of_run
);
    import avc2ab_pkg::*;

    logic  accept;
    logic  push;
    t_cmd  push_cmd;
    logic  q_full;
    logic  q_vld;
    t_cmd  q_data;
    logic  q_pop;
    t_kind kind;

    assign accept  = i_valid && !q_full;
    assign o_stall = q_full;

    avc2ab_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .i_packet_timestamp (i_packet_timestamp),
        .o_push             (push),
        .o_cmd              (push_cmd)
    );

    avc2ab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    avc2ab_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_vld             (q_vld),
        .i_q_data            (q_data),
        .o_q_pop             (q_pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_kind              (kind),
        .o_out_byte          (o_out_byte),
        .o_presentation_time (o_presentation_time),
        .o_profile           (o_profile),
        .o_last_of_run       (o_last_of_run)
    );

    assign o_kind = kind;

endmodule

>>> verif/avc_tag_to_annexb_converter_tb.sv
`timescale 1ns / 1ps
module avc_tag_to_annexb_converter_tb;
    import avc2ab_pkg::*;

    localparam int TIMEOUT_NS   = 1_000_000;
    localparam int RANDOM_BYTES = 180;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 30;
    localparam int IDLE_PERCENT = 24;

    // AVC packet types and prefix size codes
    localparam logic [7:0] PKT_SEQ_HEADER = 8'd0;
    localparam logic [7:0] PKT_NALU       = 8'd1;
    localparam logic [7:0] PKT_END_OF_SEQ = 8'd2;
    localparam logic [1:0] SIZE_CODE_2B   = 2'd1;
    localparam logic [1:0] SIZE_CODE_BAD  = 2'd2;
    localparam logic [1:0] SIZE_CODE_4B   = 2'd3;
    localparam logic [7:0] EOS_NAL_BYTE   = 8'h6A;

    typedef logic [7:0] t_byte_q[$];

    typedef enum logic [3:0] {
        PH_HEADER, PH_NAL_PREFIX, PH_NAL_DATA, PH_SPS_LEN, PH_SPS_DATA,
        PH_PPS_COUNT, PH_PPS_LEN, PH_PPS_DATA, PH_TRAIL, PH_WAIT, PH_DISCARD
    } t_parse_phase;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         stream_byte;
        logic signed [33:0] pts;
        logic [7:0]         profile;
        logic               last_of_run;
    } t_annexb;

    // Track parser state and hold the Annex B results still owed by the block
    class annexb_scoreboard;
        t_annexb      annexb_expected[$];
        t_annexb      staged[$];
        int           errors;
        t_parse_phase phase;
        logic [3:0]   pos;
        logic [7:0]   pkt_type;
        logic [23:0]  cts;
        logic [31:0]  acc;
        logic [2:0]   pfx_left;
        logic [31:0]  body_left;
        logic [4:0]   sps_left;
        logic [7:0]   pps_left;
        logic [1:0]   size_code;
        logic         info_set;
        logic [7:0]   profile_q;

        function new();
            errors    = 0;
            size_code = 2'd0;
            info_set  = 1'b0;
            profile_q = 8'd0;
            clear_packet();
        endfunction

        function void clear_packet();
            phase     = PH_HEADER;
            pos       = 4'd0;
            pkt_type  = 8'd0;
            cts       = 24'd0;
            acc       = 32'd0;
            pfx_left  = 3'd0;
            body_left = 32'd0;
            sps_left  = 5'd0;
            pps_left  = 8'd0;
        endfunction

        function void stage(t_kind kind, logic [7:0] val, logic signed [33:0] pts,
                            logic [7:0] prof);
            t_annexb r;
            r.kind        = kind;
            r.stream_byte = val;
            r.pts         = pts;
            r.profile     = prof;
            r.last_of_run = 1'b0;
            staged.push_back(r);
        endfunction

        function void stage_start_code();
            stage(KIND_BYTE, 8'h00, '0, 8'h00);
            stage(KIND_BYTE, 8'h00, '0, 8'h00);
            stage(KIND_BYTE, 8'h01, '0, 8'h00);
        endfunction

        function logic [2:0] prefix_len();
            return (size_code == SIZE_CODE_4B) ? 3'd4 : (size_code == SIZE_CODE_2B) ? 3'd2 : 3'd1;
        endfunction

        function void next_sps();
            sps_left = sps_left - 5'd1;
            if (sps_left != 0) begin
                phase    = PH_SPS_LEN;
                pfx_left = 3'd2;
                acc      = 32'd0;
            end else begin
                phase = PH_PPS_COUNT;
            end
        endfunction

        function void next_pps();
            pps_left = pps_left - 8'd1;
            if (pps_left != 0) begin
                phase    = PH_PPS_LEN;
                pfx_left = 3'd2;
                acc      = 32'd0;
            end else begin
                phase = PH_TRAIL;
            end
        endfunction

        // Advance the parser by one accepted byte and queue what it must produce
        function void convert_byte(logic [7:0] b, logic last, logic [31:0] ts);
            logic [33:0] pts_sum;
            staged.delete();
            case (phase)
                PH_HEADER: begin
                    if (pos == 4'd1) begin
                        pkt_type = b;
                    end else if (pos >= 4'd2 && pos <= 4'd4) begin
                        cts = {cts[15:0], b};
                    end else if (pos >= 4'd5 && pos <= 4'd9) begin
                        acc = {acc[23:0], b};
                    end else if (pos == 4'd10) begin
                        // latch profile and prefix size on the first full header only
                        if (!info_set) begin
                            profile_q = acc[31:24];
                            size_code = acc[1:0];
                            info_set  = 1'b1;
                            stage(KIND_STARTED, 8'h00, '0, profile_q);
                        end
                        sps_left = b[4:0];
                        if (sps_left != 0) begin
                            phase    = PH_SPS_LEN;
                            pfx_left = 3'd2;
                            acc      = 32'd0;
                        end else begin
                            phase = PH_PPS_COUNT;
                        end
                    end
                    if (pos == 4'd4) begin
                        if (pkt_type == PKT_NALU) begin
                            if (size_code == SIZE_CODE_BAD) begin
                                stage(KIND_ERROR, 8'h00, '0, 8'h00);
                                phase = PH_DISCARD;
                            end else begin
                                phase    = PH_NAL_PREFIX;
                                pfx_left = prefix_len();
                                acc      = 32'd0;
                            end
                        end else if (pkt_type != PKT_SEQ_HEADER) begin
                            phase = PH_WAIT;
                        end else begin
                            acc = 32'd0;
                        end
                    end
                    if (pos < 4'd15) pos = pos + 4'd1;
                end
                PH_NAL_PREFIX: begin
                    acc      = {acc[23:0], b};
                    pfx_left = pfx_left - 3'd1;
                    if (pfx_left == 0) begin
                        stage_start_code();
                        body_left = acc;
                        if (body_left != 0) begin
                            phase = PH_NAL_DATA;
                        end else begin
                            pfx_left = prefix_len();
                            acc      = 32'd0;
                        end
                    end
                end
                PH_NAL_DATA: begin
                    stage(KIND_BYTE, b, '0, 8'h00);
                    body_left = body_left - 32'd1;
                    if (body_left == 0) begin
                        phase    = PH_NAL_PREFIX;
                        pfx_left = prefix_len();
                        acc      = 32'd0;
                    end
                end
                PH_SPS_LEN, PH_PPS_LEN: begin
                    acc      = {16'h0000, acc[7:0], b};
                    pfx_left = pfx_left - 3'd1;
                    if (pfx_left == 0) begin
                        stage_start_code();
                        body_left = acc;
                        if (body_left != 0)
                            phase = (phase == PH_SPS_LEN) ? PH_SPS_DATA : PH_PPS_DATA;
                        else if (phase == PH_SPS_LEN)
                            next_sps();
                        else
                            next_pps();
                    end
                end
                PH_SPS_DATA, PH_PPS_DATA: begin
                    stage(KIND_BYTE, b, '0, 8'h00);
                    body_left = body_left - 32'd1;
                    if (body_left == 0) begin
                        if (phase == PH_SPS_DATA)
                            next_sps();
                        else
                            next_pps();
                    end
                end
                PH_PPS_COUNT: begin
                    pps_left = b;
                    if (pps_left != 0) begin
                        phase    = PH_PPS_LEN;
                        pfx_left = 3'd2;
                        acc      = 32'd0;
                    end else begin
                        phase = PH_TRAIL;
                    end
                end
                default: ;
            endcase

            // Close the packet: NALU time carries the signed composition offset
            if (last) begin
                if (phase == PH_NAL_PREFIX || phase == PH_NAL_DATA) begin
                    pts_sum = {2'b00, ts} + {{10{cts[23]}}, cts};
                    stage(KIND_DONE, 8'h00, pts_sum, profile_q);
                end else if (phase >= PH_SPS_LEN && phase <= PH_WAIT) begin
                    if (phase == PH_WAIT && pkt_type == PKT_END_OF_SEQ) begin
                        stage_start_code();
                        stage(KIND_BYTE, EOS_NAL_BYTE, '0, 8'h00);
                    end
                    stage(KIND_DONE, 8'h00, {2'b00, ts}, profile_q);
                end
                clear_packet();
            end

            if (staged.size() > 0) staged[staged.size() - 1].last_of_run = 1'b1;
            foreach (staged[k]) annexb_expected.push_back(staged[k]);
        endfunction

        // Compare one transfer from the block with the oldest owed result
        function void check_output(t_annexb got);
            t_annexb want;
            if (annexb_expected.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: kind=%0d byte=%02h pts=%0d prof=%02h last=%0b",
                             got.kind, got.stream_byte, got.pts, got.profile, got.last_of_run);
                return;
            end
            want = annexb_expected.pop_front();
            if (got.kind !== want.kind || got.stream_byte !== want.stream_byte ||
                got.pts !== want.pts || got.profile !== want.profile ||
                got.last_of_run !== want.last_of_run) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: want kind=%0d byte=%02h pts=%0d prof=%02h last=%0b",
                              " got kind=%0d byte=%02h pts=%0d prof=%02h last=%0b"},
                             want.kind, want.stream_byte, want.pts, want.profile,
                             want.last_of_run, got.kind, got.stream_byte, got.pts,
                             got.profile, got.last_of_run);
            end
        endfunction

        function int outstanding();
            return annexb_expected.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_data_byte = 8'h00;
    logic               i_last_byte = 1'b0;
    logic [31:0]        i_packet_timestamp = 32'h0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_kind;
    logic [7:0]         o_out_byte;
    logic signed [33:0] o_presentation_time;
    logic [7:0]         o_profile;
    logic               o_last_of_run;

    annexb_scoreboard sb;
    bit               calm = 1'b0;
    bit               hold_request = 1'b0;

    avc_tag_to_annexb_converter uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .i_packet_timestamp  (i_packet_timestamp),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_kind              (o_kind),
        .o_out_byte          (o_out_byte),
        .o_presentation_time (o_presentation_time),
        .o_profile           (o_profile),
        .o_last_of_run       (o_last_of_run)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit sender_idles();
        return !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    // Offer one byte, inserting random gaps, and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] ts);
        while (sender_idles()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_data_byte        <= b;
        i_last_byte        <= last;
        i_packet_timestamp <= ts;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.convert_byte(b, last, ts);
    endtask

    task automatic send_packet(input t_byte_q pkt, input logic [31:0] ts);
        foreach (pkt[k]) send_byte(pkt[k], k == pkt.size() - 1, ts);
    endtask

    // Drop valid and wait until every owed result has been taken
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    function automatic void push_header(ref t_byte_q p, input logic [7:0] ptype);
        logic [23:0] offset;
        case ($urandom_range(0, 5))
            0:       offset = 24'h800000;
            1:       offset = 24'h7FFFFF;
            2:       offset = 24'hFFFFFF;
            default: offset = 24'($urandom());
        endcase
        p.push_back(8'($urandom_range(0, 255)));
        p.push_back(ptype);
        p.push_back(offset[23:16]);
        p.push_back(offset[15:8]);
        p.push_back(offset[7:0]);
    endfunction

    function automatic int unit_len();
        return ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(1, 6);
    endfunction

    // Length prefix, big endian, followed by the unit body
    function automatic void push_unit(ref t_byte_q p, input int psize, input int len);
        for (int k = psize - 1; k >= 0; k--) p.push_back(8'((len >> (8 * k)) & 255));
        repeat (len) p.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Build one packet: mostly well-formed, some short, truncated or pure noise
    function automatic t_byte_q random_packet();
        t_byte_q p;
        int      pick;
        int      count;
        int      psize;
        int      cut;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            push_header(p, PKT_NALU);
            psize = (sb.size_code == SIZE_CODE_4B) ? 4 : (sb.size_code == SIZE_CODE_2B) ? 2 : 1;
            repeat ($urandom_range(0, 3)) push_unit(p, psize, unit_len());
        end else if (pick < 65) begin
            push_header(p, PKT_SEQ_HEADER);
            p.push_back(8'h01);
            repeat (4) p.push_back(8'($urandom_range(0, 255)));
            count = $urandom_range(0, 3);
            p.push_back({3'($urandom_range(0, 7)), 5'(count)});
            repeat (count) push_unit(p, 2, unit_len());
            count = $urandom_range(0, 3);
            p.push_back(8'(count));
            repeat (count) push_unit(p, 2, unit_len());
            repeat ($urandom_range(0, 2)) p.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 75) begin
            push_header(p, PKT_END_OF_SEQ);
            repeat ($urandom_range(0, 3)) p.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 85) begin
            push_header(p, 8'($urandom_range(3, 255)));
            repeat ($urandom_range(0, 3)) p.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 93) begin
            // short packet, too small to produce anything
            push_header(p, 8'($urandom_range(0, 2)));
            repeat (6) p.push_back(8'($urandom_range(0, 255)));
            cut = $urandom_range(1, (p[1] == PKT_SEQ_HEADER) ? 10 : 4);
            p = p[0:cut - 1];
        end else begin
            repeat ($urandom_range(1, 14)) p.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 99) < 10) begin
            cut = $urandom_range(1, p.size());
            p = p[0:cut - 1];
        end
        return p;
    endfunction

    // Receive side: check each transfer, stall at random or for a long hold-off
    initial begin
        t_annexb got;
        int      hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.kind        = t_kind'(o_kind);
                got.stream_byte = o_out_byte;
                got.pts         = o_presentation_time;
                got.profile     = o_profile;
                got.last_of_run = o_last_of_run;
                sb.check_output(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("avc_tag_to_annexb_converter verification failed");
        $finish;
    end

    initial begin
        t_byte_q pkt;
        int      sent;
        int      pkt_index;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short NALU packet: no output
        pkt = '{8'h17, PKT_NALU, 8'h00};
        send_packet(pkt, 32'h0000_0000);
        // 1-byte prefixes: zero length, full unit, then a unit cut by packet end
        pkt = '{8'h27, PKT_NALU, 8'h80, 8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00,
                8'h05, 8'hAA};
        send_packet(pkt, 32'h0000_0000);
        // end of sequence, offset must not reach the time
        pkt = '{8'h17, PKT_END_OF_SEQ, 8'h7F, 8'hFF, 8'hFF};
        send_packet(pkt, 32'hFFFF_FFFF);
        // largest presentation time
        pkt = '{8'h17, PKT_NALU, 8'h7F, 8'hFF, 8'hFF};
        send_packet(pkt, 32'hFFFF_FFFF);
        // unknown packet type with a trailing byte
        pkt = '{8'h17, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55};
        send_packet(pkt, $urandom());
        wait_drained();

        sent      = 0;
        pkt_index = 0;
        while (sent < RANDOM_BYTES) begin
            // long receiver hold while the sender keeps pushing
            if (pkt_index == 6) begin
                calm         = 1'b1;
                hold_request = 1'b1;
            end
            if (pkt_index == 9) calm = 1'b0;
            // stretch with no idling on either side
            if (pkt_index == 13) calm = 1'b1;
            if (pkt_index == 19) calm = 1'b0;
            if (pkt_index == 22) wait_drained();
            pkt = random_packet();
            send_packet(pkt, $urandom());
            sent += pkt.size();
            pkt_index++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("avc_tag_to_annexb_converter verification clean");
        end else begin
            $display("avc_tag_to_annexb_converter verification failed");
        end
        $finish;
    end
endmodule
